// ===== hdl/udpdfr_pkg.sv =====
package udpdfr_pkg;

   // Longest packet, in bytes before the checksum byte, that is still taken in.
   localparam int MaxPacketBytes = 65535;
   localparam int CountWidth     = $clog2(MaxPacketBytes + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MaxPacketBytes);

   // Header bytes kept for the summary (bytes 0 to 14 of the packet).
   localparam int HdrBytes = 15;
   localparam int HdrIdxW  = $clog2(HdrBytes);

   // Header layout.
   localparam logic [3:0] HdrEndConnect = 4'd15;
   localparam logic [3:0] HdrEndData    = 4'd12;
   localparam logic [3:0] HdrEndOther   = 4'd11;
   localparam int         HasSizeBit    = 7;

   // Packet types.
   localparam logic [3:0] TypeConnect = 4'd1;
   localparam logic [3:0] TypeData    = 4'd2;
   localparam logic [3:0] TypeMax     = 4'd4;

   // Result queue.
   localparam int QueueDepth = 4;
   localparam int PtrW       = $clog2(QueueDepth);

   typedef enum logic [2:0] {
      StOk           = 3'd0,
      StTooShort     = 3'd1,
      StBadType      = 3'd2,
      StSizeMismatch = 3'd3,
      StBadChecksum  = 3'd4
   } status_type;

   typedef enum logic {
      KindPayload = 1'b0,
      KindSummary = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0]  payload_byte;
      logic [7:0]  source;
      logic [7:0]  destination;
      logic [3:0]  packet_type;
      logic [11:0] flag_bits;
      logic [7:0]  session_id;
      logic [31:0] packet_signature;
      logic [15:0] seq_id;
      logic [7:0]  fragment_id;
      logic [31:0] conn_signature;
      status_type  status;
   } rsp_type;

   // Up to two results per input byte; second is only valid with first.
   typedef struct packed {
      logic    first_vld;
      rsp_type first;
      logic    second_vld;
      rsp_type second;
   } push_type;

endpackage

// ===== hdl/udpdfr_req_if.sv =====
interface udpdfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hdl/udpdfr_rsp_if.sv =====
interface udpdfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [7:0]  source_port;
   logic [7:0]  destination;
   logic [3:0]  packet_type;
   logic [11:0] flag_bits;
   logic [7:0]  session_id;
   logic [31:0] packet_signature;
   logic [15:0] seq_id;
   logic [7:0]  fragment_id;
   logic [31:0] conn_signature;
   logic [2:0]  status;

   modport source (
      output valid, output kind, output payload_byte, output source_port, output destination,
      output packet_type, output flag_bits, output session_id, output packet_signature,
      output seq_id, output fragment_id, output conn_signature, output status,
      input ready
   );
   modport sink (
      input valid, input kind, input payload_byte, input source_port, input destination,
      input packet_type, input flag_bits, input session_id, input packet_signature,
      input seq_id, input fragment_id, input conn_signature, input status,
      output ready
   );
endinterface

// ===== hdl/udpdfr_parser.sv =====
module udpdfr_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_vld,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   output udpdfr_pkg::push_type push
);

   logic [7:0]                        key_ff, key_in;
   logic [udpdfr_pkg::CountWidth-1:0] cnt_ff, cnt_in;
   logic [31:0]                       sum_ff, sum_in;
   logic [23:0]                       gather_ff, gather_in;
   logic [7:0]                        hdr_ff [udpdfr_pkg::HdrBytes];
   logic [7:0]                        hdr_in [udpdfr_pkg::HdrBytes];
   logic [7:0]                        hv     [udpdfr_pkg::HdrBytes];
   logic [15:0]                       size_ff, size_in;
   logic [7:0]                        held_ff, held_in;
   logic                              held_vld_ff, held_vld_in;

   logic [3:0]  cur_type;
   logic        has_size;
   logic [3:0]  hdr_end;
   logic [4:0]  pay_start;
   logic        take;
   logic        in_payload;
   logic [3:0]  sum_type;
   logic        sum_has_size;
   logic [15:0] pay_len;
   logic [7:0]  extra;
   logic [7:0]  ck;
   udpdfr_pkg::status_type st;
   udpdfr_pkg::rsp_type    pay_rsp, sum_rsp;

   // Header decode from stored bytes; the type byte is always stored before it matters.
   always_comb begin
      cur_type = hdr_ff[2][3:0];
      has_size = hdr_ff[2][udpdfr_pkg::HasSizeBit];
      if (cur_type <= udpdfr_pkg::TypeConnect) begin
         hdr_end = udpdfr_pkg::HdrEndConnect;
      end else if (cur_type == udpdfr_pkg::TypeData) begin
         hdr_end = udpdfr_pkg::HdrEndData;
      end else begin
         hdr_end = udpdfr_pkg::HdrEndOther;
      end
      pay_start = {1'b0, hdr_end} + (has_size ? 5'd2 : 5'd0);
      take = item_vld && !in_last && (cnt_ff != udpdfr_pkg::CountMax);
      in_payload = cnt_ff >= {{(udpdfr_pkg::CountWidth-5){1'b0}}, pay_start};
   end

   // Header as seen by the summary: a short packet's checksum byte lands in it.
   always_comb begin
      for (int k = 0; k < udpdfr_pkg::HdrBytes; k++) begin
         hv[k] = hdr_ff[k];
      end
      if (cnt_ff < udpdfr_pkg::CountWidth'(udpdfr_pkg::HdrBytes - 1)) begin
         hv[cnt_ff[udpdfr_pkg::HdrIdxW-1:0]] = in_byte;
      end
   end

   // Status and checksum of a finished packet.
   always_comb begin
      sum_type     = hv[2][3:0];
      sum_has_size = hv[2][udpdfr_pkg::HasSizeBit];
      pay_len      = 16'(cnt_ff - {{(udpdfr_pkg::CountWidth-4){1'b0}}, hdr_end} - 16'd2);
      if (cnt_ff < 16'd11) begin
         st = udpdfr_pkg::StTooShort;
      end else if (cur_type > udpdfr_pkg::TypeMax) begin
         st = udpdfr_pkg::StBadType;
      end else if ((cur_type <= udpdfr_pkg::TypeConnect && cnt_ff < 16'd14) ||
                   (cur_type == udpdfr_pkg::TypeData && cnt_ff < 16'd12)) begin
         st = udpdfr_pkg::StTooShort;
      end else if (sum_has_size &&
                   cnt_ff < {{(udpdfr_pkg::CountWidth-5){1'b0}}, 5'({1'b0, hdr_end} + 5'd2)}) begin
         st = udpdfr_pkg::StTooShort;
      end else if (sum_has_size && pay_len != size_ff) begin
         st = udpdfr_pkg::StSizeMismatch;
      end else begin
         st = udpdfr_pkg::StOk;
      end
      // A bare fifteen-byte connect packet also sums its own checksum byte.
      extra = (!sum_has_size && cnt_ff < {{(udpdfr_pkg::CountWidth-4){1'b0}}, hdr_end})
              ? in_byte : 8'd0;
      ck = key_ff + gather_ff[7:0] + gather_ff[15:8] + gather_ff[23:16]
         + sum_ff[7:0] + sum_ff[15:8] + sum_ff[23:16] + sum_ff[31:24] + extra;
      if (st == udpdfr_pkg::StOk && ck != in_byte) begin
         st = udpdfr_pkg::StBadChecksum;
      end
   end

   always_comb begin
      pay_rsp              = '0;
      pay_rsp.kind         = udpdfr_pkg::KindPayload;
      pay_rsp.payload_byte = held_ff;

      sum_rsp                  = '0;
      sum_rsp.kind             = udpdfr_pkg::KindSummary;
      sum_rsp.source           = hv[0];
      sum_rsp.destination      = hv[1];
      sum_rsp.packet_type      = sum_type;
      sum_rsp.flag_bits        = {hv[3], hv[2][7:4]};
      sum_rsp.session_id       = hv[4];
      sum_rsp.packet_signature = {hv[8], hv[7], hv[6], hv[5]};
      sum_rsp.seq_id           = {hv[10], hv[9]};
      sum_rsp.fragment_id      = (sum_type == udpdfr_pkg::TypeData) ? hv[11] : 8'd0;
      sum_rsp.conn_signature   = (sum_type <= udpdfr_pkg::TypeConnect)
                                 ? {hv[14], hv[13], hv[12], hv[11]} : 32'd0;
      sum_rsp.status           = st;
   end

   always_comb begin
      key_in      = csr_wr_en ? csr_wr_data : key_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      gather_in   = gather_ff;
      size_in     = size_ff;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      for (int k = 0; k < udpdfr_pkg::HdrBytes; k++) begin
         hdr_in[k] = hdr_ff[k];
      end
      push = '0;

      if (take) begin
         if (cnt_ff < udpdfr_pkg::CountWidth'(udpdfr_pkg::HdrBytes)) begin
            hdr_in[cnt_ff[udpdfr_pkg::HdrIdxW-1:0]] = in_byte;
         end
         case (cnt_ff[1:0])
            2'd0: gather_in[7:0] = in_byte;
            2'd1: gather_in[15:8] = in_byte;
            2'd2: gather_in[23:16] = in_byte;
            default: begin
               sum_in    = sum_ff + {in_byte, gather_ff};
               gather_in = '0;
            end
         endcase
         if (has_size) begin
            if (cnt_ff == {{(udpdfr_pkg::CountWidth-4){1'b0}}, hdr_end}) begin
               size_in[7:0] = in_byte;
            end else if (cnt_ff == {{(udpdfr_pkg::CountWidth-5){1'b0}},
                                    5'({1'b0, hdr_end} + 5'd1)}) begin
               size_in[15:8] = in_byte;
            end
         end
         if (in_payload) begin
            push.first_vld = held_vld_ff;
            push.first     = pay_rsp;
            held_in        = in_byte;
            held_vld_in    = 1'b1;
         end
         cnt_in = cnt_ff + 1'b1;
      end else if (item_vld && in_last) begin
         if (held_vld_ff) begin
            push.first_vld  = 1'b1;
            push.first      = pay_rsp;
            push.second_vld = 1'b1;
            push.second     = sum_rsp;
         end else begin
            push.first_vld = 1'b1;
            push.first     = sum_rsp;
         end
         cnt_in      = '0;
         sum_in      = '0;
         gather_in   = '0;
         size_in     = '0;
         held_in     = '0;
         held_vld_in = 1'b0;
         for (int k = 0; k < udpdfr_pkg::HdrBytes; k++) begin
            hdr_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         cnt_ff      <= '0;
         sum_ff      <= '0;
         gather_ff   <= '0;
         size_ff     <= '0;
         held_ff     <= '0;
         held_vld_ff <= 1'b0;
         for (int k = 0; k < udpdfr_pkg::HdrBytes; k++) begin
            hdr_ff[k] <= '0;
         end
      end else begin
         key_ff      <= key_in;
         cnt_ff      <= cnt_in;
         sum_ff      <= sum_in;
         gather_ff   <= gather_in;
         size_ff     <= size_in;
         held_ff     <= held_in;
         held_vld_ff <= held_vld_in;
         for (int k = 0; k < udpdfr_pkg::HdrBytes; k++) begin
            hdr_ff[k] <= hdr_in[k];
         end
      end
   end

endmodule

// ===== hdl/udpdfr_queue.sv =====
module udpdfr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  udpdfr_pkg::push_type push,
   output logic                 room,
   output udpdfr_pkg::rsp_type  head,
   output logic                 head_vld,
   input  logic                 head_rdy
);

   udpdfr_pkg::rsp_type         q_ff [udpdfr_pkg::QueueDepth];
   logic [udpdfr_pkg::PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [udpdfr_pkg::PtrW:0]   cnt_ff, cnt_in;
   logic [1:0]                  n_push;
   logic                        pop;

   always_comb begin
      n_push   = {1'b0, push.first_vld} + {1'b0, push.second_vld};
      head_vld = cnt_ff != '0;
      head     = q_ff[rd_ff];
      pop      = head_vld && head_rdy;
      // Room for the two results a last byte may bring.
      room     = cnt_ff <= (udpdfr_pkg::PtrW+1)'(udpdfr_pkg::QueueDepth - 2);
      wr_in    = wr_ff + udpdfr_pkg::PtrW'(n_push);
      rd_in    = rd_ff + udpdfr_pkg::PtrW'(pop);
      cnt_in   = cnt_ff + (udpdfr_pkg::PtrW+1)'(n_push) - (udpdfr_pkg::PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_vld) begin
         q_ff[wr_ff] <= push.first;
      end
      if (push.second_vld) begin
         q_ff[wr_ff + 1'b1] <= push.second;
      end
   end

endmodule

// ===== hdl/udp_v0_packet_deframer.sv =====
// Deframer for version-0 reliable-UDP packets, fed one byte per transfer on the
// request channel, with in_last marking the checksum byte that closes a packet.
// Packets stream at one byte per clock while the queue has room for new results; the
// parser updates its header, word-sum and length state at the acceptance edge and
// hands its results to a four-entry result queue. Payload bytes leave one byte
// late as kind 0 results; the last byte yields the held payload byte (if any) and
// then a kind 1 summary with the header fields and a status code. Only the result
// channel sets the pace: the request side is ready while the queue has room for two
// results, as a last byte may bring two results. The access key byte sum is to be
// written by the user through csr_wr_en/csr_wr_data only while the block is idle;
// the block does not enforce it. Signature checking and decryption are not done here.
module udp_v0_packet_deframer (
   input  logic         clock,
   input  logic         reset,
   udpdfr_req_if.sink   req_ch,
   udpdfr_rsp_if.source rsp_ch,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

   udpdfr_pkg::push_type push;
   udpdfr_pkg::rsp_type  head;
   logic                 room;
   logic                 accept;

   // A byte transfer happens whenever a byte is valid and the queue can absorb the worst case.
   assign req_ch.ready = room;
   assign accept       = req_ch.valid && room;

   udpdfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_vld    (accept),
      .in_byte     (req_ch.in_byte),
      .in_last     (req_ch.in_last),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push)
   );

   udpdfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .head     (head),
      .head_vld (rsp_ch.valid),
      .head_rdy (rsp_ch.ready)
   );

   // Result fields straight from the queue head.
   assign rsp_ch.kind             = head.kind;
   assign rsp_ch.payload_byte     = head.payload_byte;
   assign rsp_ch.source_port      = head.source;
   assign rsp_ch.destination      = head.destination;
   assign rsp_ch.packet_type      = head.packet_type;
   assign rsp_ch.flag_bits        = head.flag_bits;
   assign rsp_ch.session_id       = head.session_id;
   assign rsp_ch.packet_signature = head.packet_signature;
   assign rsp_ch.seq_id           = head.seq_id;
   assign rsp_ch.fragment_id      = head.fragment_id;
   assign rsp_ch.conn_signature   = head.conn_signature;
   assign rsp_ch.status           = head.status;

endmodule
